>>> rtl/tpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared widths, register map and cell types for the triangle unit.
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int COORD_BITS     = 16;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int SIDE_RAD_BITS  = 2 * DIFF_BITS;        // dx^2 + dy^2
    localparam int SIDE_BITS      = SIDE_RAD_BITS / 2;    // floor sqrt
    localparam int SIDE_REM_BITS  = SIDE_BITS + 2;
    localparam int PERIM_BITS     = 19;
    localparam int FACT_BITS      = PERIM_BITS;
    localparam int PQ_BITS        = 2 * FACT_BITS;
    localparam int AREA_RAD_BITS  = 2 * PQ_BITS;
    localparam int AREA_ROOT_BITS = AREA_RAD_BITS / 2;
    localparam int AREA_REM_BITS  = AREA_ROOT_BITS + 2;
    localparam int AREA_BITS      = 31;
    localparam int VSQ_BITS       = 2 * COORD_BITS;

    localparam int RADIUS_BITS    = 16;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;
    localparam int NUM_SIDES      = 3;

    localparam logic [APB_ADDR_BITS-1:0] REG_CIRCLE_RADIUS = 3'd0;
    localparam logic [RADIUS_BITS-1:0]   RADIUS_RESET      = 16'd80;

    // one lane of the bit-serial square root for a side length
    typedef struct packed {
        logic [SIDE_RAD_BITS-1:0] rad;
        logic [SIDE_REM_BITS-1:0] rem;
        logic [SIDE_BITS-1:0]     root;
    } t_side_st;

    typedef t_side_st [NUM_SIDES-1:0] t_side_lanes;

    typedef struct packed {
        logic [AREA_RAD_BITS-1:0]  rad;
        logic [AREA_REM_BITS-1:0]  rem;
        logic [AREA_ROOT_BITS-1:0] root;
    } t_area_st;

    typedef struct packed {
        logic [PERIM_BITS-1:0] perim;
        logic                  in_circle;
    } t_meta;

endpackage

>>> rtl/tpa_side_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_side_cell
// One root bit for each of the three side lengths.
// ----------------------------------------------------------------------------
module tpa_side_cell (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  tpa_pkg::t_side_lanes i_d,
    output tpa_pkg::t_side_lanes o_q
);
    import tpa_pkg::*;

    t_side_lanes n_q;
    t_side_lanes r_q;

    always_comb begin
        logic [SIDE_REM_BITS-1:0] rem_sh;
        logic [SIDE_REM_BITS-1:0] trial;
        logic                     ge;
        for (int l = 0; l < NUM_SIDES; l++) begin
            rem_sh = {i_d[l].rem[SIDE_REM_BITS-3:0],
                      i_d[l].rad[SIDE_RAD_BITS-1 -: 2]};
            trial  = {i_d[l].root, 2'b01};
            ge     = (rem_sh >= trial);
            n_q[l].rad  = {i_d[l].rad[SIDE_RAD_BITS-3:0], 2'b00};
            n_q[l].rem  = ge ? (rem_sh - trial) : rem_sh;
            n_q[l].root = {i_d[l].root[SIDE_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

>>> rtl/tpa_area_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpa_area_cell
// One root bit of the Heron product square root.
// ----------------------------------------------------------------------------
module tpa_area_cell (
    input  logic              i_clk,
    input  logic              i_en,
    input  tpa_pkg::t_area_st i_d,
    output tpa_pkg::t_area_st o_q
);
    import tpa_pkg::*;

    logic [AREA_REM_BITS-1:0] rem_sh;
    logic [AREA_REM_BITS-1:0] trial;
    logic                     ge;
    t_area_st                 n_q;
    t_area_st                 r_q;

    assign rem_sh = {i_d.rem[AREA_REM_BITS-3:0], i_d.rad[AREA_RAD_BITS-1 -: 2]};
    assign trial  = {i_d.root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb begin
        n_q.rad  = {i_d.rad[AREA_RAD_BITS-3:0], 2'b00};
        n_q.rem  = ge ? (rem_sh - trial) : rem_sh;
        n_q.root = {i_d.root[AREA_ROOT_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

>>> rtl/triangle_perimeter_area_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_perimeter_area_unit
// Perimeter, Heron area and circle test for one triangle per item.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream takes one triangle per item: six signed Q11.4 coordinates.
//  - Master stream gives one result per item: perimeter (Q.4), area (Q.8,
//    zero for an impossible triangle, saturated at 31 bits) and in tuser the
//    flag that all three vertices lie inside the configured circle.
//  - The APB port holds the circle radius (unsigned Q12.4, byte address 0).
//    Write it only while no item is in flight.
//  - Throughput: one item per cycle unless the receiver stalls. Latency is
//    set mostly by the two rows of square-root cells (17 cells for the
//    sides, 38 for the area), each giving one root bit.
//  - The whole pipeline advances together; when the receiver stalls with a
//    result waiting, s_tready drops and every stage holds, empty ones too.
//  - Reset (synchronous, active low) empties the pipeline and sets the
//    radius to 5.0.
// ----------------------------------------------------------------------------
module triangle_perimeter_area_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] first_x, [31:16] first_y, [47:32] second_x,
    // [63:48] second_y, [79:64] third_x, [95:80] third_y
    input  logic [95:0] s_tdata,
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [18:0] perimeter, [49:19] area, [55:50] zero
    output logic [55:0] m_tdata,
    // [0] inside_circle
    output logic [0:0]  m_tuser,
    // APB configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tpa_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [tpa_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [tpa_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);
    import tpa_pkg::*;

    localparam int DEPTH      = 4 + SIDE_BITS + 4 + AREA_ROOT_BITS + 1;
    localparam int META_DEPTH = 3 + AREA_ROOT_BITS;

    logic en;

    // ---------------- configuration ----------------
    logic [RADIUS_BITS-1:0]   r_radius;
    logic [2*RADIUS_BITS-1:0] r_rr;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CIRCLE_RADIUS)
                  ? {{(APB_DATA_BITS-RADIUS_BITS){1'b0}}, r_radius}
                  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == REG_CIRCLE_RADIUS) begin
            r_radius <= pwdata[RADIUS_BITS-1:0];
        end
    end

    // squared radius, settled long before any item uses it
    always_ff @(posedge i_clk) begin
        r_rr <= r_radius * r_radius;
    end

    // ---------------- valid chain ----------------
    logic [DEPTH-1:0] r_vld;

    assign m_tvalid = r_vld[DEPTH-1];
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_tvalid};
        end
    end

    // ---------------- stage 0: input capture ----------------
    logic signed [COORD_BITS-1:0] r_x [NUM_SIDES];
    logic signed [COORD_BITS-1:0] r_y [NUM_SIDES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < NUM_SIDES; v++) begin
                r_x[v] <= s_tdata[2*v*COORD_BITS +: COORD_BITS];
                r_y[v] <= s_tdata[(2*v+1)*COORD_BITS +: COORD_BITS];
            end
        end
    end

    // ---------------- stage 1: differences ----------------
    // sides: a = v0-v1, b = v1-v2, c = v0-v2
    logic signed [DIFF_BITS-1:0]  r_dx [NUM_SIDES];
    logic signed [DIFF_BITS-1:0]  r_dy [NUM_SIDES];
    logic signed [COORD_BITS-1:0] r_x1 [NUM_SIDES];
    logic signed [COORD_BITS-1:0] r_y1 [NUM_SIDES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx[0] <= DIFF_BITS'(r_x[0]) - DIFF_BITS'(r_x[1]);
            r_dy[0] <= DIFF_BITS'(r_y[0]) - DIFF_BITS'(r_y[1]);
            r_dx[1] <= DIFF_BITS'(r_x[1]) - DIFF_BITS'(r_x[2]);
            r_dy[1] <= DIFF_BITS'(r_y[1]) - DIFF_BITS'(r_y[2]);
            r_dx[2] <= DIFF_BITS'(r_x[0]) - DIFF_BITS'(r_x[2]);
            r_dy[2] <= DIFF_BITS'(r_y[0]) - DIFF_BITS'(r_y[2]);
            for (int v = 0; v < NUM_SIDES; v++) begin
                r_x1[v] <= r_x[v];
                r_y1[v] <= r_y[v];
            end
        end
    end

    // ---------------- stage 2: squares ----------------
    logic [SIDE_RAD_BITS-2:0] r_dx2 [NUM_SIDES];
    logic [SIDE_RAD_BITS-2:0] r_dy2 [NUM_SIDES];
    logic [VSQ_BITS-2:0]      r_x2  [NUM_SIDES];
    logic [VSQ_BITS-2:0]      r_y2  [NUM_SIDES];

    always_ff @(posedge i_clk) begin
        logic signed [SIDE_RAD_BITS-1:0] pdx, pdy;
        logic signed [VSQ_BITS-1:0]      px, py;
        if (en) begin
            for (int v = 0; v < NUM_SIDES; v++) begin
                pdx = r_dx[v] * r_dx[v];
                pdy = r_dy[v] * r_dy[v];
                px  = r_x1[v] * r_x1[v];
                py  = r_y1[v] * r_y1[v];
                r_dx2[v] <= pdx[SIDE_RAD_BITS-2:0];
                r_dy2[v] <= pdy[SIDE_RAD_BITS-2:0];
                r_x2[v]  <= px[VSQ_BITS-2:0];
                r_y2[v]  <= py[VSQ_BITS-2:0];
            end
        end
    end

    // ---------------- stage 3: sums and circle test ----------------
    t_side_lanes side_q [SIDE_BITS+1];
    t_side_lanes r_side0;
    logic        r_ins [SIDE_BITS+1];

    always_ff @(posedge i_clk) begin
        logic [VSQ_BITS-1:0] d;
        logic                ok;
        if (en) begin
            ok = 1'b1;
            for (int v = 0; v < NUM_SIDES; v++) begin
                r_side0[v].rad  <= {1'b0, r_dx2[v]} + {1'b0, r_dy2[v]};
                r_side0[v].rem  <= '0;
                r_side0[v].root <= '0;
                d  = {1'b0, r_x2[v]} + {1'b0, r_y2[v]};
                ok = ok && (d <= r_rr);
            end
            r_ins[0] <= ok;
        end
    end

    assign side_q[0] = r_side0;

    // ---------------- side square-root cells ----------------
    for (genvar k = 0; k < SIDE_BITS; k++) begin : g_side
        tpa_side_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (side_q[k]),
            .o_q   (side_q[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 1; k <= SIDE_BITS; k++) begin
                r_ins[k] <= r_ins[k-1];
            end
        end
    end

    // ---------------- perimeter and Heron factors ----------------
    logic [SIDE_BITS-1:0]  sa, sb, sc;
    logic [FACT_BITS:0]    f1, f2, f3;
    logic [FACT_BITS-1:0]  r_f1, r_f2, r_f3;
    logic                  r_degen;
    t_meta                 r_meta_sf;

    assign sa = side_q[SIDE_BITS][0].root;
    assign sb = side_q[SIDE_BITS][1].root;
    assign sc = side_q[SIDE_BITS][2].root;
    assign f1 = (FACT_BITS+1)'(sb) + (FACT_BITS+1)'(sc) - (FACT_BITS+1)'(sa);
    assign f2 = (FACT_BITS+1)'(sa) - (FACT_BITS+1)'(sb) + (FACT_BITS+1)'(sc);
    assign f3 = (FACT_BITS+1)'(sa) + (FACT_BITS+1)'(sb) - (FACT_BITS+1)'(sc);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta_sf.perim     <= PERIM_BITS'(sa) + PERIM_BITS'(sb) + PERIM_BITS'(sc);
            r_meta_sf.in_circle <= r_ins[SIDE_BITS];
            r_f1    <= f1[FACT_BITS-1:0];
            r_f2    <= f2[FACT_BITS-1:0];
            r_f3    <= f3[FACT_BITS-1:0];
            r_degen <= f1[FACT_BITS] | f2[FACT_BITS] | f3[FACT_BITS];
        end
    end

    // ---------------- Heron product ----------------
    t_meta                 r_meta [META_DEPTH];
    logic [PQ_BITS-1:0]    r_p, r_q;
    logic [PQ_BITS+FACT_BITS-1:0] r_plo, r_phi;
    t_area_st              area_q [AREA_ROOT_BITS+1];
    t_area_st              r_area0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // s*f1 and f2*f3, forced to zero for an impossible triangle
            r_p <= r_degen ? '0 : r_meta_sf.perim * r_f1;
            r_q <= r_degen ? '0 : r_f2 * r_f3;
            // full product split over the halves of q
            r_plo <= r_p * r_q[FACT_BITS-1:0];
            r_phi <= r_p * r_q[PQ_BITS-1:FACT_BITS];
            r_area0.rad  <= AREA_RAD_BITS'(r_plo)
                          + AREA_RAD_BITS'({r_phi, {FACT_BITS{1'b0}}});
            r_area0.rem  <= '0;
            r_area0.root <= '0;
            r_meta[0] <= r_meta_sf;
            for (int k = 1; k < META_DEPTH; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    assign area_q[0] = r_area0;

    // ---------------- area square-root cells ----------------
    for (genvar k = 0; k < AREA_ROOT_BITS; k++) begin : g_area
        tpa_area_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (area_q[k]),
            .o_q   (area_q[k+1])
        );
    end

    // ---------------- output register ----------------
    logic [AREA_ROOT_BITS-1:0] root;
    logic [PERIM_BITS-1:0]     r_perim_o;
    logic [AREA_BITS-1:0]      r_area_o;
    logic                      r_inside_o;

    assign root = area_q[AREA_ROOT_BITS].root;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_perim_o  <= r_meta[META_DEPTH-1].perim;
            r_inside_o <= r_meta[META_DEPTH-1].in_circle;
            // area = root / 4, saturated to 31 bits
            if (|root[AREA_ROOT_BITS-1:AREA_BITS+2]) begin
                r_area_o <= '1;
            end else begin
                r_area_o <= root[AREA_BITS+1:2];
            end
        end
    end

    assign m_tdata = {{(56-PERIM_BITS-AREA_BITS){1'b0}}, r_area_o, r_perim_o};
    assign m_tuser = r_inside_o;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for triangle_perimeter_area_unit.
// Triangles are streamed in bursts against a stalling receiver.
// Each accepted item is scored against a local perimeter/Heron/circle
// predictor. The radius register is set only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
    import tpa_pkg::*;

    localparam int LATENCY   = 64;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [18:0] perim;
        logic [30:0] area;
        logic        in_circle;
    } t_tri_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;       // fields from bit 0 up: x1, y1, x2, y2, x3, y3
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;       // fields from bit 0 up: perimeter, area, zero pad
    logic [0:0]  m_tuser;       // bit 0: inside_circle
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    triangle_perimeter_area_unit uut (.*);

    // bench copy of the radius register
    logic [RADIUS_BITS-1:0] radius_model;
    t_tri_result            results_due[$];
    int                     fail_count;
    int                     cycle_count;
    int                     burst_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic logic [63:0] root_floor(logic [127:0] v);
        logic [63:0]  res;
        logic [63:0]  cand;
        logic [127:0] sq;
        res = '0;
        for (int k = 63; k >= 0; k--) begin
            cand = res | (64'd1 << k);
            sq   = {64'd0, cand} * {64'd0, cand};
            if (sq <= v) res = cand;
        end
        return res;
    endfunction

    function automatic longint side_len(longint xa, longint ya, longint xb, longint yb);
        longint dx;
        longint dy;
        dx = xa - xb;
        dy = ya - yb;
        return longint'(root_floor(128'(dx * dx + dy * dy)));
    endfunction

    function automatic t_tri_result predict_triangle(logic [95:0] tri_data,
                                                     logic [RADIUS_BITS-1:0] radius);
        longint       x[3];
        longint       y[3];
        longint       a, b, c, s, f1, f2, f3;
        logic [127:0] prod;
        logic [63:0]  ar;
        longint       rr;
        t_tri_result  r;
        for (int v = 0; v < 3; v++) begin
            x[v] = longint'($signed(tri_data[32*v +: 16]));
            y[v] = longint'($signed(tri_data[32*v+16 +: 16]));
        end
        a  = side_len(x[0], y[0], x[1], y[1]);
        b  = side_len(x[1], y[1], x[2], y[2]);
        c  = side_len(x[0], y[0], x[2], y[2]);
        s  = a + b + c;
        f1 = -a + b + c;
        f2 = a - b + c;
        f3 = a + b - c;
        r.perim = (s > 524287) ? 19'h7FFFF : 19'(s);
        r.area  = '0;
        if (f1 >= 0 && f2 >= 0 && f3 >= 0) begin
            prod = 128'(s * f1) * 128'(f2 * f3);
            ar   = root_floor(prod) >> 2;
            r.area = (ar > 64'h7FFFFFFF) ? 31'h7FFFFFFF : 31'(ar);
        end
        rr = longint'(radius) * longint'(radius);
        r.in_circle = 1'b1;
        for (int v = 0; v < 3; v++)
            if (x[v] * x[v] + y[v] * y[v] > rr) r.in_circle = 1'b0;
        return r;
    endfunction

    // ---------------------------------------------------------------- scoreboard
    // predictions are made at acceptance, radius is stable then by construction
    always @(posedge i_clk) begin
        t_tri_result want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && s_tvalid && s_tready)
            results_due.push_back(predict_triangle(s_tdata, radius_model));
        if (i_rst_n && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result %h / %b", $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                if (m_tdata[18:0] !== want.perim) begin
                    $display("%0t: perimeter exp %0d got %0d", $time, want.perim,
                             m_tdata[18:0]);
                    fail_count++;
                end
                if (m_tdata[49:19] !== want.area) begin
                    $display("%0t: area exp %0d got %0d", $time, want.area,
                             m_tdata[49:19]);
                    fail_count++;
                end
                if (m_tdata[55:50] !== 6'd0) begin
                    $display("%0t: pad exp 0 got %h", $time, m_tdata[55:50]);
                    fail_count++;
                end
                if (m_tuser[0] !== want.in_circle) begin
                    $display("%0t: inside exp %b got %b", $time, want.in_circle,
                             m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver
    // alternates free-running stretches with random and long stalls
    initial begin
        int mode;
        int span;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 80);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: begin
                        m_tready = 1'b1;
                    end
                    1: begin
                        m_tready = ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        m_tready = ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        m_tready = ($urandom_range(0, 7) == 0);
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- sender
    task automatic send_triangle(logic [95:0] tri_data);
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = tri_data;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            @(negedge i_clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
        end
    endtask

    task automatic send_vertices(int x1, int y1, int x2, int y2, int x3, int y3);
        send_triangle({16'(y3), 16'(x3), 16'(y2), 16'(x2), 16'(y1), 16'(x1)});
    endtask

    // pipeline fully drained before touching the register
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_radius(logic [RADIUS_BITS-1:0] radius);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = REG_CIRCLE_RADIUS;
        pwdata  = {16'($urandom_range(0, 65535)), radius};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        radius_model = radius;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        psel = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[RADIUS_BITS-1:0] !== radius) begin
            $display("%0t: radius readback exp %0d got %0d", $time, radius,
                     prdata[RADIUS_BITS-1:0]);
            fail_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_corner_triangles();
        send_vertices(0, 0, 0, 0, 0, 0);
        send_vertices(32767, 32767, 32767, 32767, 32767, 32767);
        send_vertices(-32768, -32768, -32768, -32768, -32768, -32768);
        // longest sides the fields allow
        send_vertices(-32768, -32768, 32767, 32767, -32768, 32767);
        send_vertices(32767, -32768, -32768, 32767, 32767, 32767);
        send_vertices(-32768, 0, 32767, 0, 0, 32767);
        // collinear; floored sides can break the triangle inequality
        send_vertices(0, 0, 3, 5, 6, 10);
        send_vertices(-7, -11, 0, 0, 7, 11);
        send_vertices(0, 0, 100, 0, 50, 0);
        // ordinary shapes
        send_vertices(0, 0, 48, 0, 0, 64);
        send_vertices(-20, -20, 20, -20, 0, 15);
        send_vertices(1000, 2000, -3000, 500, 7, -9000);
        // vertices on and just beyond the reset radius
        send_vertices(80, 0, 0, 80, -80, 0);
        send_vertices(81, 0, 0, 80, -80, 0);
        send_vertices(48, 64, -48, -64, 0, -80);
        send_vertices(48, 65, 0, 0, 1, 1);
    endtask

    task automatic test_radius_sweep();
        logic [RADIUS_BITS-1:0] settings[4];
        settings = '{16'd0, 16'hFFFF, 16'd1, 16'(($urandom_range(0, 65535)))};
        foreach (settings[i]) begin
            wait_idle();
            write_radius(settings[i]);
            send_vertices(0, 0, 0, 0, 0, 0);
            send_vertices(1, 0, 0, 1, -1, 0);
            send_vertices(32767, 32767, -32768, -32768, 0, 0);
            send_vertices(-32768, 0, 0, 32767, 1, 1);
            for (int n = 0; n < 10; n++) send_triangle({$urandom, $urandom, $urandom});
        end
    endtask

    task automatic test_random_triangles(int count);
        int span;
        int cx;
        int cy;
        int dx;
        int dy;
        for (int n = 0; n < count; n++) begin
            if (n % 500 == 499) begin
                wait_idle();
                write_radius($urandom_range(0, 3) == 0 ? 16'($urandom) :
                             16'($urandom_range(0, 600)));
            end
            case ($urandom_range(0, 3))
                0: begin
                    send_triangle({$urandom, $urandom, $urandom});
                end
                1: begin
                    // triangles with vertices in a square just enclosing the circle
                    span = radius_model + 4;
                    if (span > 32767) span = 32767;
                    send_vertices($urandom_range(0, 2*span) - span,
                                  $urandom_range(0, 2*span) - span,
                                  $urandom_range(0, 2*span) - span,
                                  $urandom_range(0, 2*span) - span,
                                  $urandom_range(0, 2*span) - span,
                                  $urandom_range(0, 2*span) - span);
                end
                2: begin
                    // near-degenerate: third point on or next to the line through the others
                    cx = $urandom_range(0, 20000) - 10000;
                    cy = $urandom_range(0, 20000) - 10000;
                    dx = $urandom_range(0, 2000) - 1000;
                    dy = $urandom_range(0, 2000) - 1000;
                    send_vertices(cx, cy, cx + dx, cy + dy,
                                  cx + 2*dx + $urandom_range(0, 2) - 1,
                                  cy + 2*dy);
                end
                default: begin
                    span = 1 << $urandom_range(1, 15);
                    send_vertices($urandom_range(0, 2*span-1) - span,
                                  $urandom_range(0, 2*span-1) - span,
                                  $urandom_range(0, 2*span-1) - span,
                                  $urandom_range(0, 2*span-1) - span,
                                  $urandom_range(0, 2*span-1) - span,
                                  $urandom_range(0, 2*span-1) - span);
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        fail_count   = 0;
        cycle_count  = 0;
        burst_left   = 0;
        radius_model = RADIUS_RESET;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_triangles();
        test_radius_sweep();
        test_random_triangles(2000);

        wait_idle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
